// ===== sv/hbe_pkg.sv =====
// Shared constants for the Hamming ball enumerator.
package hbe_pkg;

  localparam int CFG_W = 5;
  localparam int CNT_W = 5;
  localparam int IDX_W = 1;

  localparam logic [IDX_W-1:0] REG_SEQ_LENGTH   = 1'b0;
  localparam logic [IDX_W-1:0] REG_MAX_DISTANCE = 1'b1;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_NEXT  = 1'b1;

  localparam logic [CFG_W-1:0] SEQ_LENGTH_RST   = 5'd30;
  localparam logic [CFG_W-1:0] MAX_DISTANCE_RST = 5'd20;

endpackage

// ===== sv/hamming_ball_enumerator.sv =====
// Hamming ball enumerator: walks all words within a flip distance of a center word.
//
// Input channel (in_valid/in_stall): kind 0 loads center_value and gives no
// result; kind 1 returns the current word, the mask and count of bits that
// changed against the previous word, and more_left, then advances the walk.
// Words go by flip count from zero upward; within one count the flip sets
// ascend with bit position 0 taken as most significant.
// Output channel (out_valid/out_stall): the result of a kind 1 transfer is
// registered in the output register. One item is taken every cycle while
// in_stall is low; the successor flip set is formed combinationally by a
// priority encoder and shifts on the mirrored set.
// When the receiver stalls, the output register holds and one more result
// lands in a skid register; in_stall rises only while that skid is full.
// Configuration (cfg_valid/cfg_ready, always ready) sets seq_length and
// max_distance; write only while the block is idle.
// Reset (rst, synchronous) empties both output stages, clears the center and
// the walk, and sets seq_length to 30 and max_distance to 20.
module hamming_ball_enumerator #(
  parameter int MAX_BITS = 30
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [hbe_pkg::IDX_W-1:0]   cfg_index,
  input  logic [hbe_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        kind,
  input  logic [MAX_BITS-1:0]         center_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [MAX_BITS-1:0]         word_value,
  output logic [MAX_BITS-1:0]         changed_mask,
  output logic [hbe_pkg::CNT_W-1:0]   changed_count,
  output logic                        more_left
);

  localparam int XW = MAX_BITS + 1;
  localparam logic [hbe_pkg::CFG_W-1:0] MAXB = hbe_pkg::CFG_W'(MAX_BITS);

  function automatic logic [hbe_pkg::CNT_W-1:0] pop_cnt(input logic [MAX_BITS-1:0] x);
    logic [hbe_pkg::CNT_W-1:0] c;
    c = '0;
    for (int i = 0; i < MAX_BITS; i++) begin
      c = c + hbe_pkg::CNT_W'(x[i]);
    end
    return c;
  endfunction

  function automatic logic [hbe_pkg::CFG_W-1:0] low_zeros(input logic [MAX_BITS-1:0] x);
    logic [hbe_pkg::CFG_W-1:0] c;
    c = '0;
    for (int i = MAX_BITS - 1; i >= 0; i--) begin
      if (x[i]) begin
        c = hbe_pkg::CFG_W'(i);
      end
    end
    return c;
  endfunction

  function automatic logic [MAX_BITS-1:0] rev_bits(input logic [MAX_BITS-1:0] x);
    logic [MAX_BITS-1:0] r;
    for (int i = 0; i < MAX_BITS; i++) begin
      r[i] = x[MAX_BITS-1-i];
    end
    return r;
  endfunction

  logic [hbe_pkg::CFG_W-1:0] seq_length;
  logic [hbe_pkg::CFG_W-1:0] max_distance;
  logic [MAX_BITS-1:0]       center_word;
  logic [MAX_BITS-1:0]       flip_set;
  logic [MAX_BITS-1:0]       last_diff;

  logic                      out_valid_r;
  logic [MAX_BITS-1:0]       out_word;
  logic [MAX_BITS-1:0]       out_mask;
  logic [hbe_pkg::CNT_W-1:0] out_cnt;
  logic                      out_more;
  logic                      skid_valid;
  logic [MAX_BITS-1:0]       skid_word;
  logic [MAX_BITS-1:0]       skid_mask;
  logic [hbe_pkg::CNT_W-1:0] skid_cnt;
  logic                      skid_more;

  logic [hbe_pkg::CFG_W-1:0] len;
  logic [hbe_pkg::CFG_W-1:0] dist_lim;
  logic [hbe_pkg::CFG_W-1:0] sh;
  logic [MAX_BITS-1:0]       m;
  logic [MAX_BITS-1:0]       cur;
  logic [MAX_BITS-1:0]       r;
  logic [hbe_pkg::CNT_W-1:0] w;
  logic [XW-1:0]             t;
  logic [XW-1:0]             t_inc;
  logic [XW-1:0]             low_z;
  logic [hbe_pkg::CFG_W-1:0] tz_sh;
  logic [XW-1:0]             cand;
  logic                      cand_ok;
  logic [hbe_pkg::CFG_W-1:0] fill_k;
  logic [MAX_BITS-1:0]       nxt;
  logic                      more;

  logic                      accept;
  logic                      res_valid;
  logic [MAX_BITS-1:0]       res_word;
  logic [hbe_pkg::CNT_W-1:0] res_cnt;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign accept    = in_valid && !in_stall;
  assign res_valid = accept && (kind == hbe_pkg::KIND_NEXT);

  always_comb begin
    if (seq_length == '0) begin
      len = hbe_pkg::CFG_W'(1);
    end else if (seq_length > MAXB) begin
      len = MAXB;
    end else begin
      len = seq_length;
    end
    dist_lim = (max_distance > len) ? len : max_distance;
    sh    = MAXB - len;
    m     = {MAX_BITS{1'b1}} >> sh;
    cur   = flip_set & m;
    r     = rev_bits(cur) >> sh;
    w     = pop_cnt(cur);
    t     = {1'b0, r} | ({1'b0, r} - XW'(1));
    t_inc = t + XW'(1);
    low_z = ~t & t_inc;
    tz_sh = low_zeros(r) + hbe_pkg::CFG_W'(1);
    cand  = t_inc | ((low_z - XW'(1)) >> tz_sh);
    cand_ok = (r != '0) && (cand <= {1'b0, m});
    fill_k  = hbe_pkg::CFG_W'(w) + hbe_pkg::CFG_W'(1);
    if (cand_ok) begin
      nxt = rev_bits(cand[MAX_BITS-1:0]) >> sh;
    end else begin
      nxt = m & ~(m >> fill_k);
    end
    more     = (hbe_pkg::CFG_W'(w) <= dist_lim) &&
               (cand_ok || (hbe_pkg::CFG_W'(w) < dist_lim));
    res_word = (center_word ^ cur) & m;
    res_cnt  = pop_cnt(last_diff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_length   <= hbe_pkg::SEQ_LENGTH_RST;
      max_distance <= hbe_pkg::MAX_DISTANCE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hbe_pkg::REG_SEQ_LENGTH:   seq_length   <= cfg_data;
        hbe_pkg::REG_MAX_DISTANCE: max_distance <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      center_word <= '0;
      flip_set    <= '0;
      last_diff   <= '0;
    end else if (accept) begin
      if (kind == hbe_pkg::KIND_START) begin
        center_word <= center_value & m;
        flip_set    <= '0;
        last_diff   <= '0;
      end else if (more) begin
        flip_set  <= nxt;
        last_diff <= (cur ^ nxt) & m;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_r <= 1'b0;
      skid_valid  <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      if (skid_valid) begin
        out_valid_r <= 1'b1;
        skid_valid  <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      if (skid_valid) begin
        out_word <= skid_word;
        out_mask <= skid_mask;
        out_cnt  <= skid_cnt;
        out_more <= skid_more;
      end else if (res_valid) begin
        out_word <= res_word;
        out_mask <= last_diff;
        out_cnt  <= res_cnt;
        out_more <= more;
      end
    end else if (res_valid) begin
      skid_word <= res_word;
      skid_mask <= last_diff;
      skid_cnt  <= res_cnt;
      skid_more <= more;
    end
  end

  assign out_valid     = out_valid_r;
  assign word_value    = out_word;
  assign changed_mask  = out_mask;
  assign changed_count = out_cnt;
  assign more_left     = out_more;

endmodule

// ===== sv/hbe_check.sv =====
// Port-level checks for the Hamming ball enumerator, bound to the top level.
module hbe_check #(
  parameter int MAX_BITS = 30
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      kind,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [MAX_BITS-1:0]       word_value,
  input logic [MAX_BITS-1:0]       changed_mask,
  input logic [hbe_pkg::CNT_W-1:0] changed_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(word_value) && $stable(changed_mask)))
    else $error("stalled output transfer changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> $past(out_valid && out_stall))
    else $error("input stalled without a held output");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($countones(changed_mask) == changed_count))
    else $error("changed_count does not match changed_mask");

  a_next_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (kind == hbe_pkg::KIND_NEXT) && (!out_valid || !out_stall))
      |=> out_valid)
    else $error("next transfer gave no result");

  a_start_silent: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (kind == hbe_pkg::KIND_START) && !out_valid) |=> !out_valid)
    else $error("start transfer gave a result");

endmodule

bind hamming_ball_enumerator hbe_check #(.MAX_BITS(MAX_BITS)) u_hbe_check (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .kind          (kind),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .word_value    (word_value),
  .changed_mask  (changed_mask),
  .changed_count (changed_count)
);
